// ===== rtl/core/sma_pkg.sv =====
// shared constants and helpers for the streaming moving average
// no dependencies; imported by every module of the block
`default_nettype none

package sma_pkg;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(8);

    // zero means one sample, anything above the ring depth means the full ring
    function automatic logic [CFG_W-1:0] clamp_length(input logic [CFG_W-1:0] wl,
                                                      input int unsigned wmax);
        logic [CFG_W-1:0] n;
        if (wl == '0)
        begin
            n = CFG_W'(1);
        end
        else if (32'(wl) > wmax)
        begin
            n = CFG_W'(wmax);
        end
        else
        begin
            n = wl;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sma_front.sv =====
// front end: takes samples, keeps the sample ring and the running sum
// classifies each request as warm-up or full window; depends on sma_pkg
`default_nettype none

module sma_front #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 24,
    parameter int SUM_W        = 30
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [sma_pkg::CFG_W-1:0]   window_length,
    input  wire logic                        sample_valid,
    output logic                             sample_ready,
    input  wire logic [SAMPLE_WIDTH-1:0]     sample,
    output logic                             push,
    input  wire logic                        push_ready,
    output logic                             push_full,
    output logic [SUM_W-1:0]                 push_sum
);
    import sma_pkg::*;

    localparam int DEPTH  = (WINDOW_MAX < (1 << CFG_W)) ? WINDOW_MAX : (1 << CFG_W) - 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                           state_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] old_reg;
    logic [CFG_W-1:0]               fill_reg;
    logic signed [SUM_W-1:0]        sum_reg;
    logic [ADDR_W-1:0]              ptr_reg;

    logic [SAMPLE_WIDTH-1:0]        ring_mem [DEPTH];

    logic [CFG_W-1:0]               n;
    logic                           warm;
    logic [ADDR_W-1:0]              ptr_eff;
    logic [ADDR_W-1:0]              wr_addr;
    logic [CFG_W-1:0]               fill_inc;
    logic [CFG_W-1:0]               ptr_inc;
    logic [ADDR_W-1:0]              ptr_next;
    logic signed [SUM_W-1:0]        old_ext;
    logic signed [SUM_W-1:0]        sum_next;
    logic                           update;

    always_comb
    begin
        n        = clamp_length(window_length, WINDOW_MAX);
        warm     = fill_reg < n;
        ptr_eff  = (CFG_W'(ptr_reg) >= n) ? '0 : ptr_reg;
        wr_addr  = warm ? fill_reg[ADDR_W-1:0] : ptr_eff;
        fill_inc = fill_reg + CFG_W'(1);
        ptr_inc  = CFG_W'(ptr_eff) + CFG_W'(1);
        ptr_next = (ptr_inc >= n) ? '0 : ptr_inc[ADDR_W-1:0];
        // oldest sample leaves the sum only once the window is full
        old_ext  = warm ? '0 : SUM_W'(old_reg);
        sum_next = sum_reg + SUM_W'(sample_reg) - old_ext;
        update   = (state_reg == ST_UPD) && push_ready;
    end

    assign sample_ready = (state_reg == ST_IDLE);
    assign push         = (state_reg == ST_UPD);
    assign push_full    = warm ? (fill_inc == n) : 1'b1;
    assign push_sum     = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            sum_reg   <= '0;
            ptr_reg   <= '0;
        end
        else if (cfg_we)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            sum_reg   <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_valid)
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    if (push_ready)
                    begin
                        state_reg <= ST_IDLE;
                        sum_reg   <= sum_next;
                        if (warm)
                        begin
                            fill_reg <= fill_inc;
                        end
                        else
                        begin
                            ptr_reg <= ptr_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            sample_reg <= sample;
        end
        if (update)
        begin
            ring_mem[wr_addr] <= sample_reg;
        end
        // read of the oldest slot lands by the time the update state looks at it
        old_reg <= ring_mem[ptr_eff];
    end

endmodule

`default_nettype wire

// ===== rtl/core/sma_queue.sv =====
// two-entry queue between the front end and the divider back end
// carries the window sum and the full-window flag; depends on sma_pkg
`default_nettype none

module sma_queue #(
    parameter int W = 31
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              push_ready,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic              pop_valid,
    output logic [W-1:0]      pop_data
);
    import sma_pkg::*;

    logic [W-1:0] entry_mem [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         do_push;
    logic         do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sma_back.sv =====
// back end: bit-serial signed divide of the window sum by the window length
// drives the output register; depends on sma_pkg
`default_nettype none

module sma_back #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 24,
    parameter int SUM_W        = 30
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [sma_pkg::CFG_W-1:0] window_length,
    input  wire logic                      pop_valid,
    output logic                           pop,
    input  wire logic                      pop_full,
    input  wire logic [SUM_W-1:0]          pop_sum,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [SAMPLE_WIDTH-1:0]        out_average,
    output logic                           out_valid_res
);
    import sma_pkg::*;

    localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]              state_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_WIDTH-1:0] out_avg_reg;
    logic                    out_res_reg;
    logic                    neg_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic [CFG_W-1:0]        rem_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic [CFG_W-1:0]        n;
    logic                    out_free;
    logic                    out_load;
    logic [CFG_W:0]          rem_sh;
    logic [CFG_W:0]          rem_diff;
    logic                    ge;
    logic [SUM_W-1:0]        quo_signed;
    logic [SUM_W-1:0]        sum_mag;

    always_comb
    begin
        n          = clamp_length(window_length, WINDOW_MAX);
        out_free   = !out_valid_reg || out_ready;
        rem_sh     = {rem_reg, quo_reg[SUM_W-1]};
        rem_diff   = rem_sh - {1'b0, n};
        ge         = rem_sh >= {1'b0, n};
        quo_signed = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
        sum_mag    = pop_sum[SUM_W-1] ? (~pop_sum + SUM_W'(1)) : pop_sum;
        pop        = (state_reg == ST_IDLE) && pop_valid && (pop_full || out_free);
        // warm-up request or finished divide goes to the output register
        out_load   = (pop && !pop_full) || ((state_reg == ST_FIN) && out_free);
    end

    assign out_valid     = out_valid_reg;
    assign out_average   = out_avg_reg;
    assign out_valid_res = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop && pop_full)
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= '0;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(SUM_W - 1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && pop)
        begin
            neg_reg <= pop_sum[SUM_W-1];
            quo_reg <= sum_mag;
            rem_reg <= '0;
            if (!pop_full)
            begin
                // warm-up request, nothing to divide
                out_avg_reg <= '0;
                out_res_reg <= 1'b0;
            end
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= ge ? rem_diff[CFG_W-1:0] : rem_sh[CFG_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
        end
        else if (state_reg == ST_FIN && out_free)
        begin
            // magnitude quotient with the sign put back truncates toward zero
            out_avg_reg <= quo_signed[SAMPLE_WIDTH-1:0];
            out_res_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/streaming_moving_average.sv =====
// moving average over the last N samples, kept as a running sum
// a request passes the front-end update state, the queue and the bit-serial divider,
// which works through the SUM_W bits of the sum (SUM_W = SAMPLE_WIDTH + log2 WINDOW_MAX, 30 by default)
// the divider takes no new request until it has finished the last one
// warm-up requests leave the divider out
// reset: asynchronous, active low; window length 8, warm-up restarted, ring contents undefined
`default_nettype none

module streaming_moving_average #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [sma_pkg::CFG_W-1:0]             cfg_wdata,     // window_length
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata, // sample
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]  m_axis_tdata,  // average
    output logic                                       m_axis_tuser   // valid_res
);
    import sma_pkg::*;

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SUM_W   = SAMPLE_WIDTH + $clog2(WINDOW_MAX);

    logic [CFG_W-1:0]        window_length_reg;
    logic                    push;
    logic                    push_ready;
    logic                    push_full;
    logic [SUM_W-1:0]        push_sum;
    logic                    pop;
    logic                    pop_valid;
    logic [SUM_W:0]          pop_data;
    logic [SAMPLE_WIDTH-1:0] average;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_length_reg <= cfg_wdata;
        end
    end

    sma_front #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SUM_W        (SUM_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .window_length (window_length_reg),
        .sample_valid  (s_axis_tvalid),
        .sample_ready  (s_axis_tready),
        .sample        (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .push          (push),
        .push_ready    (push_ready),
        .push_full     (push_full),
        .push_sum      (push_sum)
    );

    sma_queue #(
        .W (SUM_W + 1)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  ({push_full, push_sum}),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    sma_back #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SUM_W        (SUM_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (window_length_reg),
        .pop_valid     (pop_valid),
        .pop           (pop),
        .pop_full      (pop_data[SUM_W]),
        .pop_sum       (pop_data[SUM_W-1:0]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_average   (average),
        .out_valid_res (m_axis_tuser)
    );

    assign m_axis_tdata = TDATA_W'(average);

endmodule

`default_nettype wire
